[design/hea_pkg.sv]
// Shared types, widths and functions of the hash edge aggregator.
// No dependencies; imported by hash_edge_aggregator_unit, its checker and its testbench.
package hea_pkg;

    // Default number of hash slots in the table
    localparam int DEF_TABLE_SLOTS = 64;

    // Field widths fixed by the item format
    localparam int KEY_W    = 31;
    localparam int SUM_W    = 32;
    localparam int WGT_W    = 16;
    localparam int CNT_W    = 7;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 72;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIFORM    = 2'd1;

    // Reset value of the size register
    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 7'd64;

    // Command codes
    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Hash remainder: hash bits consumed per cycle and steps per remainder
    localparam int MOD_BITS  = 8;
    localparam int MOD_STEPS = 32 / MOD_BITS;
    localparam int STEP_W    = $clog2(MOD_STEPS);

    // One table slot as held in memory
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [SUM_W-1:0] sum;
    } slot_entry_t;

    localparam int ENTRY_W = KEY_W + SUM_W;

    // 32-bit xorshift of a key: 13 left, 17 right, 5 left
    function automatic logic [31:0] mix_key(input logic [KEY_W-1:0] k);
        logic [31:0] x;
        x = {1'b0, k};
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

endpackage

[design/hash_edge_aggregator_unit.sv]
// Hash edge aggregator: open-addressed table with linear probing, flush by sweep.
// An accumulate runs the hashed key through the 8-bit-per-cycle remainder unit and
// probes from the remainder: an empty slot is claimed, an occupied one is read and
// compared; a self loop is dropped. A flush emits each occupied slot in slot order, or
// one marker item on an empty table, holding on output stalls. Items are taken only
// while idle. Reset (aresetn low, sync) clears the valid bits, count, overflow flag,
// config and output valid; keys and sums stay as is. Depends on hea_pkg and hea_ram.
module hash_edge_aggregator_unit #(
    parameter int TABLE_SLOTS = hea_pkg::DEF_TABLE_SLOTS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tdata: row_key[30:0], neighbor_key[61:31], edge_weight[77:62], zero fill
    input  logic [hea_pkg::IN_DATA_W-1:0]    s_tdata,
    // tuser: command
    input  logic                             s_tuser,
    // Result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // tdata: entry_key[30:0], entry_sum[62:31], unique_count[69:63],
    //        overflowed[70], zero fill
    output logic [hea_pkg::OUT_DATA_W-1:0]   m_tdata,
    // tuser: entry_valid
    output logic                             m_tuser,
    output logic                             m_tlast,
    // Configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hea_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hea_pkg::CFG_W-1:0]        cfg_data
);

    import hea_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int SZ_W  = $clog2(TABLE_SLOTS + 1);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_MOD     = 3'd1;
    localparam logic [2:0] ST_PROBE   = 3'd2;
    localparam logic [2:0] ST_CMP     = 3'd3;
    localparam logic [2:0] ST_FL_SCAN = 3'd4;
    localparam logic [2:0] ST_FL_READ = 3'd5;
    localparam logic [2:0] ST_FL_EMPTY = 3'd6;

    logic [2:0]             state_reg, state_next;
    logic [31:0]            hash_reg, hash_next;
    logic [SZ_W-1:0]        rem_reg, rem_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [SZ_W-1:0]        size_reg, size_next;
    logic [WGT_W-1:0]       add_reg, add_next;
    logic [KEY_W-1:0]       nbr_reg, nbr_next;
    logic [IDX_W-1:0]       pos_reg, pos_next;
    logic [SZ_W-1:0]        probe_reg, probe_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       emit_reg, emit_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic [TABLE_SLOTS-1:0] valid_reg, valid_next;
    logic [CFG_W-1:0]       cfg_size_reg, cfg_size_next;
    logic                   cfg_unif_reg, cfg_unif_next;

    logic                   out_valid_reg, out_valid_next;
    logic [KEY_W-1:0]       out_key_reg, out_key_next;
    logic [SUM_W-1:0]       out_sum_reg, out_sum_next;
    logic                   out_ev_reg, out_ev_next;
    logic [CNT_W-1:0]       out_cnt_reg, out_cnt_next;
    logic                   out_ovf_reg, out_ovf_next;
    logic                   out_last_reg, out_last_next;

    logic                   in_fire;
    logic                   out_free;
    logic                   in_cmd;
    logic [KEY_W-1:0]       in_row;
    logic [KEY_W-1:0]       in_nbr;
    logic [WGT_W-1:0]       in_wgt;
    logic [SZ_W-1:0]        live_size;
    logic [SZ_W-1:0]        rem_step;
    logic [SUM_W:0]         sum_wide;
    logic [SUM_W-1:0]       sum_sat;
    logic [IDX_W-1:0]       pos_inc;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    slot_entry_t            ram_wdata;
    logic                   ram_re;
    logic [IDX_W-1:0]       ram_raddr;
    slot_entry_t            ram_rdata;

    // Unpack the input item
    assign in_cmd = s_tuser;
    assign in_row = s_tdata[KEY_W-1:0];
    assign in_nbr = s_tdata[2*KEY_W-1:KEY_W];
    assign in_wgt = s_tdata[2*KEY_W+WGT_W-1:2*KEY_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;

    // Clamp the configured size into 1..TABLE_SLOTS
    always_comb begin
        if (cfg_size_reg == '0) begin
            live_size = SZ_W'(1);
        end else if (cfg_size_reg > CFG_W'(TABLE_SLOTS)) begin
            live_size = SZ_W'(TABLE_SLOTS);
        end else begin
            live_size = cfg_size_reg[SZ_W-1:0];
        end
    end

    // Remainder unit: fold the next hash byte into the running remainder
    always_comb begin
        logic [SZ_W:0] t;
        logic [SZ_W-1:0] r;
        r = rem_reg;
        for (int b = 0; b < MOD_BITS; b++) begin
            t = {r, hash_reg[31-b]};
            if (t >= {1'b0, size_reg}) begin
                t = t - {1'b0, size_reg};
            end
            r = t[SZ_W-1:0];
        end
        rem_step = r;
    end

    // Saturating add of the edge weight to the slot sum
    assign sum_wide = {1'b0, ram_rdata.sum} + {{(SUM_W+1-WGT_W){1'b0}}, add_reg};
    assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

    // Next probe position with wraparound at the size in use
    assign pos_inc = (SZ_W'(pos_reg) + SZ_W'(1) == size_reg) ? '0 : pos_reg + 1'b1;

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        size_next      = size_reg;
        add_next       = add_reg;
        nbr_next       = nbr_reg;
        pos_next       = pos_reg;
        probe_next     = probe_reg;
        idx_next       = idx_reg;
        emit_next      = emit_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        valid_next     = valid_reg;
        cfg_size_next  = cfg_size_reg;
        cfg_unif_next  = cfg_unif_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_key_next   = out_key_reg;
        out_sum_next   = out_sum_reg;
        out_ev_next    = out_ev_reg;
        out_cnt_next   = out_cnt_reg;
        out_ovf_next   = out_ovf_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = '{key: nbr_reg, sum: sum_sat};
        ram_re         = 1'b0;
        ram_raddr      = pos_reg;

        // Take configuration writes; indexes beyond the list are dropped
        if (cfg_valid) begin
            case (cfg_index)
                CFG_TABLE_SIZE: cfg_size_next = cfg_data;
                CFG_UNIFORM:    cfg_unif_next = cfg_data[0];
                default:        ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (in_cmd == CMD_FLUSH) begin
                        idx_next   = '0;
                        emit_next  = '0;
                        state_next = (count_reg == '0) ? ST_FL_EMPTY : ST_FL_SCAN;
                    end else if (in_row != in_nbr) begin
                        hash_next  = mix_key(in_nbr);
                        rem_next   = '0;
                        step_next  = '0;
                        size_next  = live_size;
                        add_next   = cfg_unif_reg ? WGT_W'(1) : in_wgt;
                        nbr_next   = in_nbr;
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                rem_next  = rem_step;
                hash_next = hash_reg << MOD_BITS;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(MOD_STEPS - 1)) begin
                    pos_next   = rem_step[IDX_W-1:0];
                    probe_next = '0;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (!valid_reg[pos_reg]) begin
                    // Empty slot: claim it with the first weight
                    ram_we              = 1'b1;
                    ram_wdata.sum       = {{(SUM_W-WGT_W){1'b0}}, add_reg};
                    valid_next[pos_reg] = 1'b1;
                    count_next          = count_reg + 1'b1;
                    state_next          = ST_IDLE;
                end else begin
                    ram_re     = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (ram_rdata.key == nbr_reg) begin
                    ram_we     = 1'b1;
                    state_next = ST_IDLE;
                end else if (probe_reg + 1'b1 == size_reg) begin
                    // Every probed slot holds another key: drop the edge
                    ovf_next   = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    probe_next = probe_reg + 1'b1;
                    pos_next   = pos_inc;
                    state_next = ST_PROBE;
                end
            end
            ST_FL_SCAN: begin
                ram_raddr = idx_reg;
                if (valid_reg[idx_reg]) begin
                    ram_re     = 1'b1;
                    state_next = ST_FL_READ;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_FL_READ: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_key_next   = ram_rdata.key;
                    out_sum_next   = ram_rdata.sum;
                    out_ev_next    = 1'b1;
                    out_cnt_next   = count_reg;
                    out_ovf_next   = ovf_reg;
                    out_last_next  = (emit_reg + 1'b1 == count_reg);
                    emit_next      = emit_reg + 1'b1;
                    if (emit_reg + 1'b1 == count_reg) begin
                        valid_next = '0;
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_FL_SCAN;
                    end
                end
            end
            ST_FL_EMPTY: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_key_next   = '0;
                    out_sum_next   = '0;
                    out_ev_next    = 1'b0;
                    out_cnt_next   = count_reg;
                    out_ovf_next   = ovf_reg;
                    out_last_next  = 1'b1;
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            valid_reg     <= '0;
            cfg_size_reg  <= CFG_SIZE_RESET;
            cfg_unif_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            valid_reg     <= valid_next;
            cfg_size_reg  <= cfg_size_next;
            cfg_unif_reg  <= cfg_unif_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge aclk) begin
        hash_reg     <= hash_next;
        rem_reg      <= rem_next;
        step_reg     <= step_next;
        size_reg     <= size_next;
        add_reg      <= add_next;
        nbr_reg      <= nbr_next;
        pos_reg      <= pos_next;
        probe_reg    <= probe_next;
        idx_reg      <= idx_next;
        emit_reg     <= emit_next;
        out_key_reg  <= out_key_next;
        out_sum_reg  <= out_sum_next;
        out_ev_reg   <= out_ev_next;
        out_cnt_reg  <= out_cnt_next;
        out_ovf_reg  <= out_ovf_next;
        out_last_reg <= out_last_next;
    end

    // Slot keys and sums
    hea_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Pack the result item
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-KEY_W-SUM_W-CNT_W-1){1'b0}},
                       out_ovf_reg, out_cnt_reg, out_sum_reg, out_key_reg};
    assign m_tuser  = out_ev_reg;
    assign m_tlast  = out_last_reg;

    // The distinct count always matches the occupied slots
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        32'($countones(valid_reg)) == 32'(count_reg))
        else $error("distinct count differs from occupied slots");

    // Probing stays inside the size in use
    a_probe_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE || state_reg == ST_CMP) |->
            (SZ_W'(pos_reg) < size_reg && probe_reg < size_reg))
        else $error("probe position outside the table in use");

    // A flush read targets an occupied slot
    a_flush_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FL_READ) |-> valid_reg[idx_reg])
        else $error("flush read of an empty slot");

    // The last item of a flush leaves the table empty and is sent with tlast
    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FL_READ && out_free && emit_reg + 1'b1 == count_reg)
            |=> (valid_reg == '0 && count_reg == '0 && !ovf_reg && m_tlast && m_tvalid))
        else $error("table not cleared after the last flush item");

    // An accepted accumulate that is no self loop starts the hash remainder
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && in_cmd == CMD_ACCUM && in_row != in_nbr |=> state_reg == ST_MOD)
        else $error("accumulate did not start the hash remainder");

endmodule

[design/hea_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module hea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; hold the data while no read is issued
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[verif/hea_table_checker.sv]
// Checker for hash_edge_aggregator_unit: mirrors the hash table from accepted input
// and config items, and compares every flushed table entry in order.
// Depends on hea_pkg; instantiated by tb_hash_edge_aggregator_unit.
module hea_table_checker #(
    parameter int TABLE_SLOTS = hea_pkg::DEF_TABLE_SLOTS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [hea_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                             s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [hea_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                             m_tuser,
    input  logic                             m_tlast,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [hea_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hea_pkg::CFG_W-1:0]        cfg_data,
    output int unsigned                      fail_count,
    output int unsigned                      pending_entries,
    output int unsigned                      entries_checked,
    output int unsigned                      flushes_seen,
    output int unsigned                      overflow_rows
);
    timeunit 1ns;
    timeprecision 1ps;

    import hea_pkg::*;

    // Bit positions inside the packed data words
    localparam int IN_NBR_LO   = KEY_W;
    localparam int IN_WGT_LO   = 2 * KEY_W;
    localparam int OUT_SUM_LO  = KEY_W;
    localparam int OUT_CNT_LO  = KEY_W + SUM_W;
    localparam int OUT_OVF_BIT = KEY_W + SUM_W + CNT_W;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [SUM_W-1:0] sum;
        logic             valid;
        logic [CNT_W-1:0] count;
        logic             ovf;
        logic             last;
    } table_entry_t;

    // Mirrored table, counters and registers
    logic [KEY_W-1:0] slot_key_m  [TABLE_SLOTS];
    logic             slot_used_m [TABLE_SLOTS];
    logic [SUM_W-1:0] slot_sum_m  [TABLE_SLOTS];
    logic [CNT_W-1:0] distinct_m;
    logic             overflow_m;
    logic [CFG_W-1:0] size_reg_m;
    logic             uniform_m;

    table_entry_t flush_entries_q[$];

    int unsigned errors    = 0;
    int unsigned n_checked = 0;
    int unsigned n_flushes = 0;
    int unsigned n_ovf     = 0;

    // xorshift over the zero-extended key
    function automatic logic [31:0] scramble_key(input logic [KEY_W-1:0] k);
        logic [31:0] h;
        h = {1'b0, k};
        h = h ^ (h << 13);
        h = h ^ (h >> 17);
        h = h ^ (h << 5);
        return h;
    endfunction

    // Slots probed under the current size register, clamped to the table
    function automatic int unsigned probe_span();
        int unsigned span;
        span = 32'(size_reg_m);
        if (span < 1) span = 1;
        if (span > TABLE_SLOTS) span = TABLE_SLOTS;
        return span;
    endfunction

    task automatic clear_table();
        for (int s = 0; s < TABLE_SLOTS; s++) begin
            slot_used_m[s] = 1'b0;
            slot_key_m[s]  = '0;
            slot_sum_m[s]  = '0;
        end
        distinct_m = '0;
        overflow_m = 1'b0;
    endtask

    // Insert or update one edge; drop self loops, flag a full table
    task automatic merge_edge(input logic [KEY_W-1:0] row, input logic [KEY_W-1:0] nbr,
                              input logic [WGT_W-1:0] wgt);
        int unsigned span;
        int unsigned pos;
        logic [SUM_W-1:0] add;
        logic [SUM_W:0]   total;
        if (row == nbr) return;
        span = probe_span();
        pos  = scramble_key(nbr) % span;
        add  = uniform_m ? SUM_W'(1) : SUM_W'(wgt);
        for (int n = 0; n < span; n++) begin
            if (!slot_used_m[pos]) begin
                slot_used_m[pos] = 1'b1;
                slot_key_m[pos]  = nbr;
                slot_sum_m[pos]  = '0;
                distinct_m       = distinct_m + 1'b1;
            end
            if (slot_key_m[pos] == nbr) begin
                total = {1'b0, slot_sum_m[pos]} + {1'b0, add};
                slot_sum_m[pos] = total[SUM_W] ? '1 : total[SUM_W-1:0];
                return;
            end
            pos = (pos + 1 >= span) ? 0 : pos + 1;
        end
        overflow_m = 1'b1;
    endtask

    // Queue the occupied slots in slot order, or the empty marker, then clear
    task automatic drain_table();
        int unsigned occupied;
        int unsigned k;
        table_entry_t e;
        occupied = 0;
        k        = 0;
        for (int s = 0; s < TABLE_SLOTS; s++)
            if (slot_used_m[s]) occupied++;
        for (int s = 0; s < TABLE_SLOTS; s++) begin
            if (slot_used_m[s]) begin
                k++;
                e.key   = slot_key_m[s];
                e.sum   = slot_sum_m[s];
                e.valid = 1'b1;
                e.count = distinct_m;
                e.ovf   = overflow_m;
                e.last  = (k == occupied);
                flush_entries_q.push_back(e);
            end
        end
        if (occupied == 0) begin
            e.key   = '0;
            e.sum   = '0;
            e.valid = 1'b0;
            e.count = distinct_m;
            e.ovf   = overflow_m;
            e.last  = 1'b1;
            flush_entries_q.push_back(e);
        end
        n_flushes++;
        if (overflow_m) n_ovf++;
        clear_table();
    endtask

    task automatic note_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Compare one result item with the oldest queued entry
    task automatic check_entry();
        table_entry_t got;
        table_entry_t want;
        got.key   = m_tdata[KEY_W-1:0];
        got.sum   = m_tdata[OUT_SUM_LO +: SUM_W];
        got.count = m_tdata[OUT_CNT_LO +: CNT_W];
        got.ovf   = m_tdata[OUT_OVF_BIT];
        got.valid = m_tuser;
        got.last  = m_tlast;
        if (flush_entries_q.size() == 0) begin
            errors++;
            $display("%0t: result with no flush entry waiting, actual key %h sum %h last %b",
                     $time, got.key, got.sum, got.last);
            return;
        end
        want = flush_entries_q.pop_front();
        n_checked++;
        note_field("entry_key", 32'(want.key), 32'(got.key));
        note_field("entry_sum", want.sum, got.sum);
        note_field("entry_valid", 32'(want.valid), 32'(got.valid));
        note_field("unique_count", 32'(want.count), 32'(got.count));
        note_field("overflowed", 32'(want.ovf), 32'(got.ovf));
        note_field("last", 32'(want.last), 32'(got.last));
    endtask

    // Track every handshake at the clock edge; publish counters by nonblocking update
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_table();
            size_reg_m = CFG_SIZE_RESET;
            uniform_m  = 1'b0;
            flush_entries_q.delete();
        end else begin
            if (m_tvalid && m_tready) check_entry();
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TABLE_SIZE: size_reg_m = cfg_data;
                    CFG_UNIFORM:    uniform_m  = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == CMD_FLUSH) begin
                    drain_table();
                end else begin
                    merge_edge(s_tdata[KEY_W-1:0], s_tdata[IN_NBR_LO +: KEY_W],
                               s_tdata[IN_WGT_LO +: WGT_W]);
                end
            end
        end
        pending_entries <= flush_entries_q.size();
        fail_count      <= errors;
        entries_checked <= n_checked;
        flushes_seen    <= n_flushes;
        overflow_rows   <= n_ovf;
    end

endmodule

[verif/tb_hash_edge_aggregator_unit.sv]
// Testbench top for hash_edge_aggregator_unit: drives edge and flush items with
// random idle gaps, writes the config registers between rows and mid-row, and gives the verdict.
// Depends on hea_pkg, the block's RTL and hea_table_checker.
module tb_hash_edge_aggregator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import hea_pkg::*;

    localparam int TABLE_SLOTS    = DEF_TABLE_SLOTS;
    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int MAX_GAP        = 14;
    localparam int SETTLE_CYCLES  = 160;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TARGET_ITEMS   = 330;
    localparam int FILL_PHASE     = 4;
    localparam int POOL_DEPTH     = 8;
    localparam int PAD_W          = IN_DATA_W - 2 * KEY_W - WGT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam logic [KEY_W-1:0]     KEY_MAX       = '1;
    localparam logic [WGT_W-1:0]     WGT_MAX       = '1;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata;
    logic                    s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic                    m_tuser;
    logic                    m_tlast;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_data;

    int unsigned fail_count;
    int unsigned pending_entries;
    int unsigned entries_checked;
    int unsigned flushes_seen;
    int unsigned overflow_rows;

    int unsigned items_sent  = 0;
    int unsigned idle_cycles = 0;
    bit          quiet_phase = 1'b0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    hash_edge_aggregator_unit #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hea_table_checker #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_entries (pending_entries),
        .entries_checked (entries_checked),
        .flushes_seen    (flushes_seen),
        .overflow_rows   (overflow_rows)
    );

    // Idle cycles before the next item; none during quiet rows
    function automatic int unsigned draw_gap();
        return quiet_phase ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Present one item and hold it until accepted; keep valid high across back-to-back items
    task automatic send_item(input logic cmd, input logic [KEY_W-1:0] row,
                             input logic [KEY_W-1:0] nbr, input logic [WGT_W-1:0] wgt);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{PAD_W{1'b0}}, wgt, nbr, row};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Write one register; with more set, valid stays high for the next write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data,
                             input bit more);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (!more) cfg_valid <= 1'b0;
    endtask

    // Stop sending, wait for every queued entry, then let a worst-case probe run out
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_entries != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_flush();
        send_item(CMD_FLUSH, KEY_W'($urandom), KEY_W'($urandom), WGT_W'($urandom));
    endtask

    // Result side: stall a random number of cycles before each item
    initial begin : result_sink
        int unsigned stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = draw_gap();
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Abort when no channel moves an item for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired after %0d cycles without a handshake",
                     $time, idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [KEY_W-1:0] pool [POOL_DEPTH];
        logic [KEY_W-1:0] key_a;
        logic [KEY_W-1:0] key_b;
        logic [KEY_W-1:0] row;
        logic [KEY_W-1:0] nbr;
        logic [WGT_W-1:0] wgt;
        logic [CFG_W-1:0] size_val;
        int unsigned      phase;
        int unsigned      n_acc;
        int unsigned      pool_n;
        bit               fill;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= CMD_ACCUM;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_TABLE_SIZE;
        cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty flush and extreme keys under the reset configuration
        quiet_phase = 1'b1;
        send_flush();
        send_item(CMD_ACCUM, KEY_MAX, KEY_MAX, WGT_MAX);
        send_item(CMD_ACCUM, KEY_MAX, '0, WGT_MAX);
        send_item(CMD_ACCUM, '0, KEY_MAX, '0);
        send_item(CMD_ACCUM, 31'h2AAA_AAAA, '0, 16'h0001);
        send_item(CMD_ACCUM, '0, 31'h5555_5555, 16'h8000);
        send_item(CMD_ACCUM, KEY_MAX, 31'h2AAA_AAAA, 16'h7FFF);
        send_flush();
        quiesce();

        // Size zero acts as one slot; uniform bit with the upper data bits set
        write_reg(CFG_TABLE_SIZE, '0, 1'b1);
        write_reg(CFG_UNIFORM, '1, 1'b0);
        quiet_phase = 1'b0;
        key_a = KEY_W'($urandom);
        key_b = ~key_a;
        send_item(CMD_ACCUM, key_b, key_a, WGT_MAX);
        send_item(CMD_ACCUM, '0, key_a, 16'h1234);
        send_item(CMD_ACCUM, key_a, key_b, 16'h0010);
        send_flush();
        send_flush();
        quiesce();

        // Oversized size clamps to the full table; spare index is ignored
        write_reg(CFG_IDX_SPARE, 7'h55, 1'b1);
        write_reg(CFG_TABLE_SIZE, '1, 1'b1);
        write_reg(CFG_UNIFORM, '0, 1'b0);
        repeat (4) send_item(CMD_ACCUM, KEY_W'($urandom), KEY_W'($urandom), WGT_W'($urandom));
        quiesce();
        // Shrink mid-row: earlier slots beyond the new size must still flush
        write_reg(CFG_TABLE_SIZE, 7'd2, 1'b0);
        repeat (3) send_item(CMD_ACCUM, KEY_W'($urandom), KEY_W'($urandom), WGT_W'($urandom));
        send_flush();
        quiesce();

        // Random rows over a small key pool, one row that overfills the full table
        phase = 0;
        while (items_sent < TARGET_ITEMS) begin
            quiet_phase = ($urandom_range(0, 3) == 0);
            fill        = (phase == FILL_PHASE);
            case ($urandom_range(0, 5))
                0:       size_val = CFG_W'($urandom_range(0, 2));
                1:       size_val = CFG_W'($urandom_range(3, 8));
                2:       size_val = CFG_W'($urandom_range(9, TABLE_SLOTS - 1));
                3:       size_val = CFG_W'(TABLE_SLOTS);
                4:       size_val = CFG_W'($urandom_range(TABLE_SLOTS + 1, 127));
                default: size_val = CFG_W'($urandom_range(1, 16));
            endcase
            if (fill) size_val = CFG_W'(TABLE_SLOTS);
            write_reg(CFG_TABLE_SIZE, size_val, 1'b1);
            write_reg(CFG_UNIFORM, CFG_W'($urandom_range(0, 127)), 1'b0);

            pool_n = $urandom_range(1, POOL_DEPTH);
            for (int k = 0; k < POOL_DEPTH; k++) pool[k] = KEY_W'($urandom);
            if ($urandom_range(0, 3) == 0) pool[0] = '0;
            if ($urandom_range(0, 3) == 0) pool[pool_n - 1] = KEY_MAX;
            n_acc = fill ? TABLE_SLOTS + 2 : $urandom_range(1, 20);

            for (int k = 0; k < n_acc; k++) begin
                nbr = fill ? KEY_W'($urandom) : pool[$urandom_range(0, pool_n - 1)];
                // Keep the overfill row free of self loops so every edge needs a slot
                row = (!fill && $urandom_range(0, 7) == 0) ? nbr : KEY_W'($urandom);
                case ($urandom_range(0, 7))
                    0:       wgt = '0;
                    1:       wgt = WGT_MAX;
                    default: wgt = WGT_W'($urandom);
                endcase
                // Occasionally change the size in the middle of a row
                if (!fill && k == n_acc / 2 && $urandom_range(0, 3) == 0) begin
                    quiesce();
                    write_reg(CFG_TABLE_SIZE, CFG_W'($urandom_range(0, 127)), 1'b0);
                end
                send_item(CMD_ACCUM, row, nbr, wgt);
            end
            send_flush();
            if ($urandom_range(0, 5) == 0) send_flush();
            quiesce();
            phase++;
        end

        $display("Sent %0d items in %0d rows; %0d flushes produced %0d table entries.",
                 items_sent, phase, flushes_seen, entries_checked);
        $display("Rows that ran into a full table: %0d.", overflow_rows);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
